### design/hrf_pkg.sv
// Shared types, codes and pattern functions of the HTTP request framer.
`default_nettype none

package hrf_pkg;

    localparam int KIND_W = 3;
    localparam int HDR_W  = 13;
    localparam int BODY_W = 12;
    localparam int TOT_W  = 13;

    localparam logic [KIND_W-1:0] KIND_READY     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FRAUD     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MALFORMED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 3'd4;

    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_C   = 8'h63;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] request_kind;
        logic [HDR_W-1:0]  header_length;
        logic [BODY_W-1:0] body_length;
        logic [TOT_W-1:0]  total_length;
    } t_result;

    function automatic logic [7:0] meth_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0:    c = "P";
            2'd1:    c = "O";
            2'd2:    c = "S";
            default: c = "T";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] fraud_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = "/";
            4'd1:    c = "f";
            4'd2:    c = "r";
            4'd3:    c = "a";
            4'd4:    c = "u";
            4'd5:    c = "d";
            4'd6:    c = "-";
            4'd7:    c = "s";
            4'd8:    c = "c";
            4'd9:    c = "o";
            4'd10:   c = "r";
            4'd11:   c = "e";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ready_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = "/";
            4'd1:    c = "r";
            4'd2:    c = "e";
            4'd3:    c = "a";
            4'd4:    c = "d";
            4'd5:    c = "y";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "content-length:" with letters case-insensitive
    function automatic logic name_ok(input logic [3:0] pos, input logic [7:0] b);
        logic [7:0] c;
        logic       ok;
        unique case (pos)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        if (c >= "a" && c <= "z") begin
            ok = ((b | CASE_BIT) == c);
        end else begin
            ok = (b == c);
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

### design/hrf_ifs.sv
// Valid/ready channel interfaces for the framer's byte input and result output.
`default_nettype none

interface hrf_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, func, data_byte, input ready);
    modport sink   (input valid, func, data_byte, output ready);
endinterface

interface hrf_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  request_kind;
    logic [12:0] header_length;
    logic [11:0] body_length;
    logic [12:0] total_length;

    modport source (output valid, request_kind, header_length, body_length, total_length,
                    input ready);
    modport sink   (input valid, request_kind, header_length, body_length, total_length,
                    output ready);
endinterface

`default_nettype wire

### design/hrf_in_reg.sv
// Input register stage: holds one byte item until the parser consumes it.
`default_nettype none

module hrf_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire hrf_pkg::t_in_item i_item,
    output logic                   o_ready,
    input  wire logic              i_advance,
    output logic                   o_valid,
    output hrf_pkg::t_in_item      o_item
);
    import hrf_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_take;

    assign o_ready = !r_valid || i_advance;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

`default_nettype wire

### design/hrf_parser.sv
// Parser state and single-step update: header matchers, length decode, body count.
`default_nettype none

module hrf_parser #(
    parameter int REQUEST_LIMIT = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire hrf_pkg::t_in_item i_item,
    output logic                   o_res_valid,
    output hrf_pkg::t_result       o_res
);
    import hrf_pkg::*;

    localparam int CNT_W = $clog2(REQUEST_LIMIT + 1);
    localparam int MUL_W = CNT_W + 4;
    localparam logic [CNT_W-1:0] LIMIT     = CNT_W'(REQUEST_LIMIT);
    localparam logic [MUL_W-1:0] LIMIT_EXT = MUL_W'(REQUEST_LIMIT);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_CLOSED = 2'd2;

    localparam logic [1:0] DP_BLANK  = 2'd0;
    localparam logic [1:0] DP_DIGITS = 2'd1;
    localparam logic [1:0] DP_DONE   = 2'd2;

    localparam logic [2:0] METH_DONE = 3'd4;
    localparam logic [2:0] METH_MISS = 3'd5;
    localparam logic [2:0] BLANK_END = 3'd4;
    localparam logic [3:0] NAME_END  = 4'd15;
    localparam logic [3:0] FRAUD_LEN = 4'd12;
    localparam logic [3:0] READY_LEN = 4'd6;
    localparam logic [3:0] TIDX_MAX  = 4'd15;

    logic [1:0]       r_phase,     n_phase;
    logic [CNT_W-1:0] r_req_bytes, n_req_bytes;
    logic [2:0]       r_blank,     n_blank;
    logic [2:0]       r_meth,      n_meth;
    logic [1:0]       r_space,     n_space;
    logic [3:0]       r_tidx,      n_tidx;
    logic [1:0]       r_flags,     n_flags;
    logic [3:0]       r_nprog,     n_nprog;
    logic             r_found,     n_found;
    logic [1:0]       r_dphase,    n_dphase;
    logic [CNT_W-1:0] r_len_value, n_len_value;
    logic [CNT_W-1:0] r_body_rem,  n_body_rem;

    always_comb begin : p_next
        logic [CNT_W-1:0] rb;
        logic [CNT_W-1:0] br;
        logic [CNT_W-1:0] cl;
        logic [MUL_W-1:0] v;
        logic [7:0]       b;
        logic             is_digit;
        logic             do_clear;
        logic             do_fin;
        logic             do_ovf;

        n_phase     = r_phase;
        n_req_bytes = r_req_bytes;
        n_blank     = r_blank;
        n_meth      = r_meth;
        n_space     = r_space;
        n_tidx      = r_tidx;
        n_flags     = r_flags;
        n_nprog     = r_nprog;
        n_found     = r_found;
        n_dphase    = r_dphase;
        n_len_value = r_len_value;
        n_body_rem  = r_body_rem;

        b        = i_item.data_byte;
        is_digit = (b >= CH_0) && (b <= CH_9);
        rb       = r_req_bytes + 1'b1;
        br       = r_body_rem - 1'b1;
        cl       = '0;
        v        = '0;
        do_clear = 1'b0;
        do_fin   = 1'b0;
        do_ovf   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_fire) begin
            if (i_item.func) begin
                do_clear = 1'b1;
            end else if (r_phase != PH_CLOSED) begin
                n_req_bytes = rb;
                if (r_phase == PH_BODY) begin
                    n_body_rem = br;
                    if (br == '0) begin
                        do_fin = 1'b1;
                    end else begin
                        do_ovf = (rb >= LIMIT);
                    end
                end else begin
                    // method
                    if (r_meth < METH_DONE) begin
                        n_meth = (b == meth_char(r_meth[1:0])) ? r_meth + 3'd1 : METH_MISS;
                    end

                    // target between the first two spaces
                    if (r_space == 2'd0) begin
                        if (b == CH_SP) begin
                            n_space = 2'd1;
                        end
                    end else if (r_space == 2'd1) begin
                        if (b == CH_SP) begin
                            n_space = 2'd2;
                            if (r_tidx != FRAUD_LEN) n_flags[0] = 1'b0;
                            if (r_tidx != READY_LEN) n_flags[1] = 1'b0;
                        end else begin
                            if (r_tidx >= FRAUD_LEN || b != fraud_char(r_tidx)) begin
                                n_flags[0] = 1'b0;
                            end
                            if (r_tidx >= READY_LEN || b != ready_char(r_tidx)) begin
                                n_flags[1] = 1'b0;
                            end
                            if (r_tidx < TIDX_MAX) begin
                                n_tidx = r_tidx + 4'd1;
                            end
                        end
                    end

                    // content length value, else its name
                    if (r_found) begin
                        unique case (r_dphase)
                            DP_BLANK: begin
                                if (is_digit) begin
                                    n_len_value = CNT_W'(b[3:0]);
                                    n_dphase    = DP_DIGITS;
                                end else if (b != CH_SP && b != CH_TAB) begin
                                    n_dphase = DP_DONE;
                                end
                            end
                            DP_DIGITS: begin
                                if (is_digit) begin
                                    v = (MUL_W'(r_len_value) << 3) + (MUL_W'(r_len_value) << 1)
                                        + MUL_W'(b[3:0]);
                                    n_len_value = (v > LIMIT_EXT) ? LIMIT : v[CNT_W-1:0];
                                end else begin
                                    n_dphase = DP_DONE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else begin
                        if (r_nprog < NAME_END && name_ok(r_nprog, b)) begin
                            n_nprog = r_nprog + 4'd1;
                        end else begin
                            n_nprog = ((b | CASE_BIT) == CH_C) ? 4'd1 : 4'd0;
                        end
                        if (n_nprog == NAME_END) begin
                            n_found     = 1'b1;
                            n_dphase    = DP_BLANK;
                            n_len_value = '0;
                        end
                    end

                    // header end
                    if (b == CH_CR) begin
                        n_blank = (r_blank == 3'd2) ? 3'd3 : 3'd1;
                    end else if (b == CH_LF && (r_blank == 3'd1 || r_blank == 3'd3)) begin
                        n_blank = r_blank + 3'd1;
                    end else begin
                        n_blank = 3'd0;
                    end

                    if (n_blank == BLANK_END) begin
                        if (n_space < 2'd2) begin
                            o_res_valid                = 1'b1;
                            o_res.request_kind         = KIND_MALFORMED;
                            o_res.header_length        = HDR_W'(rb);
                            o_res.total_length         = TOT_W'(rb);
                            n_phase                    = PH_CLOSED;
                        end else begin
                            cl = (n_meth == METH_DONE && n_found) ? n_len_value : '0;
                            n_len_value = cl;
                            if (cl == '0) begin
                                do_fin = 1'b1;
                            end else begin
                                n_phase    = PH_BODY;
                                n_body_rem = cl;
                                do_ovf     = (rb >= LIMIT);
                            end
                        end
                    end else begin
                        do_ovf = (rb >= LIMIT);
                    end
                end
            end
        end

        if (do_fin) begin
            o_res_valid = 1'b1;
            if (n_flags[1]) begin
                o_res.request_kind = KIND_READY;
            end else if (n_meth == METH_DONE && n_flags[0]) begin
                o_res.request_kind = KIND_FRAUD;
            end else begin
                o_res.request_kind = KIND_NOT_FOUND;
            end
            o_res.header_length = HDR_W'(rb - n_len_value);
            o_res.body_length   = BODY_W'(n_len_value);
            o_res.total_length  = TOT_W'(rb);
            do_clear            = 1'b1;
        end

        if (do_ovf) begin
            o_res_valid   = 1'b1;
            o_res         = '0;
            o_res.request_kind = KIND_OVERFLOW;
            o_res.total_length = TOT_W'(REQUEST_LIMIT);
            n_phase       = PH_CLOSED;
        end

        if (do_clear) begin
            n_phase     = PH_HEADER;
            n_req_bytes = '0;
            n_blank     = 3'd0;
            n_meth      = 3'd0;
            n_space     = 2'd0;
            n_tidx      = 4'd0;
            n_flags     = 2'b11;
            n_nprog     = 4'd0;
            n_found     = 1'b0;
            n_dphase    = DP_BLANK;
            n_len_value = '0;
            n_body_rem  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_req_bytes <= '0;
            r_blank     <= 3'd0;
            r_meth      <= 3'd0;
            r_space     <= 2'd0;
            r_tidx      <= 4'd0;
            r_flags     <= 2'b11;
            r_nprog     <= 4'd0;
            r_found     <= 1'b0;
            r_dphase    <= DP_BLANK;
            r_len_value <= '0;
            r_body_rem  <= '0;
        end else begin
            r_phase     <= n_phase;
            r_req_bytes <= n_req_bytes;
            r_blank     <= n_blank;
            r_meth      <= n_meth;
            r_space     <= n_space;
            r_tidx      <= n_tidx;
            r_flags     <= n_flags;
            r_nprog     <= n_nprog;
            r_found     <= n_found;
            r_dphase    <= n_dphase;
            r_len_value <= n_len_value;
            r_body_rem  <= n_body_rem;
        end
    end
endmodule

`default_nettype wire

### design/hrf_out_reg.sv
// Result register: holds one finished request record until its transfer.
`default_nettype none

module hrf_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire hrf_pkg::t_result i_res,
    input  wire logic             i_ready,
    output logic                  o_space,
    output logic                  o_valid,
    output hrf_pkg::t_result      o_res
);
    import hrf_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

`default_nettype wire

### design/http_request_framer_unit.sv
// Top level of the HTTP/1.1 request framer.
// The ending byte goes from the input register through the parser into the result register.
// 1 byte/cycle unless the result stage stalls; each matcher and counter steps once per byte.
// Reset (synchronous, active low) empties both stages and returns the parser to the
// header phase of a fresh connection; no clearing pass is needed.
`default_nettype none

module http_request_framer_unit #(
    parameter int REQUEST_LIMIT = 4096
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hrf_in_if.sink     i_req,
    hrf_out_if.source  o_res
);
    import hrf_pkg::*;

    t_in_item w_in_item;
    t_in_item w_item;
    t_result  w_res;
    t_result  w_out;
    logic     w_in_ready;
    logic     w_in_full;
    logic     w_advance;
    logic     w_fire;
    logic     w_res_valid;
    logic     w_out_valid;

    assign w_in_item.func      = i_req.func;
    assign w_in_item.data_byte = i_req.data_byte;

    hrf_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_req.valid),
        .i_item    (w_in_item),
        .o_ready   (w_in_ready),
        .i_advance (w_advance),
        .o_valid   (w_in_full),
        .o_item    (w_item)
    );

    assign w_fire = w_in_full && w_advance;

    hrf_parser #(
        .REQUEST_LIMIT (REQUEST_LIMIT)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    hrf_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_ready (o_res.ready),
        .o_space (w_advance),
        .o_valid (w_out_valid),
        .o_res   (w_out)
    );

    assign i_req.ready         = w_in_ready;
    assign o_res.valid         = w_out_valid;
    assign o_res.request_kind  = w_out.request_kind;
    assign o_res.header_length = w_out.header_length;
    assign o_res.body_length   = w_out.body_length;
    assign o_res.total_length  = w_out.total_length;

    a_res_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_fire)
        else $error("result produced without a consumed byte");

    a_new_conn_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_item.func) |-> !w_res_valid)
        else $error("new connection produced a result");

    a_full_take_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && w_in_full) |-> w_advance)
        else $error("input stage overwritten while held");

    a_malformed_lengths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.request_kind == KIND_MALFORMED)
            |-> (o_res.header_length == o_res.total_length && o_res.body_length == '0))
        else $error("malformed record lengths inconsistent");
endmodule

`default_nettype wire
